FILE: rtl/dhst_pkg.sv
`default_nettype none
package dhst_pkg;

  localparam int KEY_W         = 31;
  localparam int TYPE_W        = 2;
  localparam int CFG_W         = 11;
  localparam int SLOT_OUT_W    = 10;
  localparam int SLOTS_DEFAULT = 1024;

  localparam logic [CFG_W-1:0] SIZE_MIN    = CFG_W'(5);
  localparam logic [CFG_W-1:0] SIZE_RESET  = CFG_W'(1021);
  localparam logic [CFG_W-1:0] STEP_OFFSET = CFG_W'(3);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [TYPE_W-1:0] etype;
  } slot_rd_t;

  typedef struct packed {
    logic             done;
    logic [CFG_W-1:0] rem_base;
    logic [CFG_W-1:0] rem_step;
  } mod_res_t;

endpackage
`default_nettype wire

FILE: rtl/dhst_mod_unit.sv
`default_nettype none
module dhst_mod_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [dhst_pkg::KEY_W-1:0]  key,
  input  wire logic [dhst_pkg::CFG_W-1:0]  div_base,
  input  wire logic [dhst_pkg::CFG_W-1:0]  div_step,
  output dhst_pkg::mod_res_t               res
);
  import dhst_pkg::*;

  localparam int CNT_W = $clog2(KEY_W + 1);

  logic [KEY_W-1:0] kreg;
  logic [CFG_W-1:0] d0;
  logic [CFG_W-1:0] d1;
  logic [CFG_W-1:0] r0;
  logic [CFG_W-1:0] r1;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic             done;

  logic [CFG_W:0] t0;
  logic [CFG_W:0] t1;
  logic [CFG_W:0] r0_next;
  logic [CFG_W:0] r1_next;

  // one restoring step for each divisor
  always_comb begin
    t0 = {r0, kreg[KEY_W-1]};
    t1 = {r1, kreg[KEY_W-1]};
    r0_next = (t0 >= {1'b0, d0}) ? t0 - {1'b0, d0} : t0;
    r1_next = (t1 >= {1'b0, d1}) ? t1 - {1'b0, d1} : t1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(KEY_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      kreg <= key;
      d0   <= div_base;
      d1   <= div_step;
      r0   <= '0;
      r1   <= '0;
    end else if (running) begin
      kreg <= {kreg[KEY_W-2:0], 1'b0};
      r0   <= r0_next[CFG_W-1:0];
      r1   <= r1_next[CFG_W-1:0];
    end
  end

  assign res.done     = done;
  assign res.rem_base = r0;
  assign res.rem_step = r1;

endmodule
`default_nettype wire

FILE: rtl/dhst_store.sv
`default_nettype none
module dhst_store #(
  parameter int SLOTS = dhst_pkg::SLOTS_DEFAULT,
  parameter int AW    = $clog2(SLOTS)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [dhst_pkg::KEY_W-1:0]  wr_key,
  input  wire logic [dhst_pkg::TYPE_W-1:0] wr_type,
  output dhst_pkg::slot_rd_t               rd_data,
  output logic                             clearing
);
  import dhst_pkg::*;

  logic                      valid_mem [SLOTS];
  logic [KEY_W+TYPE_W-1:0]   data_mem  [SLOTS];
  logic [AW-1:0]             clr_addr;
  logic                      rd_valid;
  logic [KEY_W+TYPE_W-1:0]   rd_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(SLOTS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      valid_mem[clr_addr] <= 1'b0;
    end else if (wr_en) begin
      valid_mem[wr_addr] <= 1'b1;
    end
    if (rd_en) begin
      rd_valid <= valid_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !clearing) begin
      data_mem[wr_addr] <= {wr_key, wr_type};
    end
    if (rd_en) begin
      rd_word <= data_mem[rd_addr];
    end
  end

  assign rd_data.valid = rd_valid;
  assign rd_data.key   = rd_word[KEY_W+TYPE_W-1:TYPE_W];
  assign rd_data.etype = rd_word[TYPE_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/double_hash_symbol_table.sv
`default_nettype none
// One item at a time; the 31-step dual remainder unit and the
//   probe loop (memory read, then compare) set the pace.
// A new input transfer is taken while a finished result waits at the output.
// Reset: synchronous; table_size returns to 1021 and a clearing pass over all SLOTS
//   entries empties the slot valid store, with no input transfer taken meanwhile.
module double_hash_symbol_table #(
  parameter int SLOTS = dhst_pkg::SLOTS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [dhst_pkg::CFG_W-1:0]      cfg_wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            cmd,
  input  wire logic [dhst_pkg::KEY_W-1:0]      key,
  input  wire logic [dhst_pkg::TYPE_W-1:0]     entry_type,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 found,
  output logic                                 inserted,
  output logic                                 table_full,
  output logic [dhst_pkg::SLOT_OUT_W-1:0]      first_slot,
  output logic [dhst_pkg::SLOT_OUT_W-1:0]      final_slot
);
  import dhst_pkg::*;

  localparam int AW = $clog2(SLOTS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MOD   = 5'b00010,
    S_READ  = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0]  table_size;
  logic [CFG_W-1:0]  p_eff;
  logic [CFG_W-1:0]  p;
  logic              cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [TYPE_W-1:0] type_q;
  logic [CFG_W-1:0]  base;
  logic [CFG_W-1:0]  step;
  logic [CFG_W-1:0]  slot;
  logic [CFG_W-1:0]  cnt;
  logic              hit;
  logic              full;

  logic              clearing;
  slot_rd_t          rd;
  mod_res_t          mres;
  logic              accept;
  logic              out_free;
  logic              do_write;

  logic [CFG_W:0]    sum;
  logic [CFG_W-1:0]  slot_adv;
  logic [CFG_W-1:0]  cnt_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      table_size <= cfg_wr_data;
    end
  end

  always_comb begin
    priority if (table_size < SIZE_MIN) begin
      p_eff = SIZE_MIN;
    end else if (32'(table_size) > 32'(SLOTS)) begin
      p_eff = CFG_W'(SLOTS);
    end else begin
      p_eff = table_size;
    end
  end

  assign in_ready = (state == S_IDLE) && !clearing;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign do_write = (state == S_DONE) && out_free && (cmd_q == CMD_INSERT) && !hit && !full;

  dhst_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .key      (key),
    .div_base (p_eff),
    .div_step (p_eff - STEP_OFFSET),
    .res      (mres)
  );

  dhst_store #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (state == S_READ),
    .rd_addr  (AW'(slot)),
    .wr_en    (do_write),
    .wr_addr  (AW'(slot)),
    .wr_key   (key_q),
    .wr_type  (type_q),
    .rd_data  (rd),
    .clearing (clearing)
  );

  always_comb begin
    sum      = {1'b0, slot} + {1'b0, step};
    slot_adv = (sum >= {1'b0, p}) ? CFG_W'(sum - {1'b0, p}) : sum[CFG_W-1:0];
    cnt_inc  = cnt + CFG_W'(1);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_MOD;
      S_MOD:   if (mres.done) state_next = S_READ;
      S_READ:  state_next = S_CHECK;
      S_CHECK: begin
        if (!rd.valid || rd.key == key_q || cnt_inc == p) begin
          state_next = S_DONE;
        end else begin
          state_next = S_READ;
        end
      end
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd;
      key_q  <= key;
      type_q <= entry_type;
      p      <= p_eff;
    end
    if (state == S_MOD && mres.done) begin
      base <= mres.rem_base;
      slot <= mres.rem_base;
      step <= mres.rem_step + CFG_W'(1);
      cnt  <= '0;
      hit  <= 1'b0;
      full <= 1'b0;
    end
    if (state == S_CHECK) begin
      priority if (!rd.valid) begin
        hit <= 1'b0;
      end else if (rd.key == key_q) begin
        hit <= 1'b1;
      end else if (cnt_inc == p) begin
        full <= 1'b1;
        slot <= base;
      end else begin
        cnt  <= cnt_inc;
        slot <= slot_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      found      <= hit;
      inserted   <= do_write;
      table_full <= full;
      first_slot <= base[SLOT_OUT_W-1:0];
      final_slot <= slot[SLOT_OUT_W-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dhst_pkg::*;

  localparam int TABLE_DEPTH = SLOTS_DEFAULT;

  typedef struct packed {
    logic                  found;
    logic                  inserted;
    logic                  full;
    logic [SLOT_OUT_W-1:0] start_slot;
    logic [SLOT_OUT_W-1:0] stop_slot;
  } reply_t;

  class symbol_table_mirror;
    logic [CFG_W-1:0]  table_size;
    bit                occupied[TABLE_DEPTH];
    logic [KEY_W-1:0]  stored_key[TABLE_DEPTH];
    logic [TYPE_W-1:0] stored_tag[TABLE_DEPTH];
    reply_t            pending_replies[$];
    int                errors;

    function new();
      table_size = SIZE_RESET;
      errors = 0;
      foreach (occupied[i]) occupied[i] = 1'b0;
    endfunction

    function void log_request(logic op, logic [KEY_W-1:0] k, logic [TYPE_W-1:0] tag);
      int unsigned p;
      int unsigned base;
      int unsigned stride;
      int unsigned slot;
      int unsigned i;
      reply_t r;
      p = table_size;
      if (p < SIZE_MIN) p = SIZE_MIN;
      if (p > TABLE_DEPTH) p = TABLE_DEPTH;
      base = k % p;
      stride = 1 + k % (p - STEP_OFFSET);
      slot = base;
      r = '0;
      r.full = 1'b1;
      for (i = 0; i < p; i++) begin
        slot = (base + i * stride) % p;
        if (!occupied[slot]) begin
          r.full = 1'b0;
          break;
        end
        if (stored_key[slot] == k) begin
          r.found = 1'b1;
          r.full = 1'b0;
          break;
        end
      end
      if (r.full) slot = base;
      if (op == CMD_INSERT && !r.found && !r.full) begin
        occupied[slot] = 1'b1;
        stored_key[slot] = k;
        stored_tag[slot] = tag;
        r.inserted = 1'b1;
      end
      r.start_slot = SLOT_OUT_W'(base);
      r.stop_slot = SLOT_OUT_W'(slot);
      pending_replies.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected reply: found=%0b ins=%0b full=%0b first=%0d final=%0d",
                   got.found, got.inserted, got.full, got.start_slot, got.stop_slot);
        return;
      end
      want = pending_replies.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("reply mismatch: want found=%0b ins=%0b full=%0b first=%0d final=%0d, %s",
                   want.found, want.inserted, want.full, want.start_slot, want.stop_slot,
                   $sformatf("got found=%0b ins=%0b full=%0b first=%0d final=%0d",
                             got.found, got.inserted, got.full, got.start_slot,
                             got.stop_slot));
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  cmd = CMD_INSERT;
  logic [KEY_W-1:0]      key = '0;
  logic [TYPE_W-1:0]     entry_type = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  found;
  logic                  inserted;
  logic                  table_full;
  logic [SLOT_OUT_W-1:0] first_slot;
  logic [SLOT_OUT_W-1:0] final_slot;

  symbol_table_mirror mirror = new();
  logic [KEY_W-1:0]   known_keys[$];
  int                 ready_hold = 0;

  double_hash_symbol_table #(.SLOTS(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .key(key),
    .entry_type(entry_type),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .found(found),
    .inserted(inserted),
    .table_full(table_full),
    .first_slot(first_slot),
    .final_slot(final_slot)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      out_ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) ready_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      mirror.check_reply({found, inserted, table_full, first_slot, final_slot});
  end

  task automatic send_item(input logic op, input logic [KEY_W-1:0] k,
                           input logic [TYPE_W-1:0] tag);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    key <= k;
    entry_type <= tag;
    do @(posedge clk); while (!in_ready);
    mirror.log_request(op, k, tag);
    if (op == CMD_INSERT) known_keys.push_back(k);
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    while (mirror.pending_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] size);
    drain_replies();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mirror.table_size = size;
  endtask

  task automatic random_item();
    int r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    k = KEY_W'($urandom);
    if (known_keys.size() != 0 && r >= 40 && r < 80)
      k = known_keys[$urandom_range(0, known_keys.size() - 1)];
    if (r >= 95) k = KEY_W'($urandom_range(0, 63));
    send_item((r >= 55 && r < 95) ? CMD_LOOKUP : CMD_INSERT, k,
              TYPE_W'($urandom_range(0, 3)));
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] size, input int count);
    write_size(size);
    repeat (count) begin
      random_item();
      if ($urandom_range(0, 99) == 0) drain_replies();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // five-slot table: empty miss, duplicates, tag 3, key extremes, then full
    write_size(CFG_W'(5));
    send_item(CMD_LOOKUP, KEY_W'(0), TYPE_W'(0));
    send_item(CMD_INSERT, KEY_W'(0), TYPE_W'(0));
    send_item(CMD_INSERT, KEY_W'(0), TYPE_W'(2));
    send_item(CMD_LOOKUP, KEY_W'(0), TYPE_W'(1));
    send_item(CMD_INSERT, KEY_W'(5), TYPE_W'(1));
    send_item(CMD_INSERT, {KEY_W{1'b1}}, TYPE_W'(3));
    send_item(CMD_INSERT, KEY_W'(10), TYPE_W'(2));
    send_item(CMD_INSERT, KEY_W'(3), TYPE_W'(1));
    send_item(CMD_INSERT, KEY_W'(20), TYPE_W'(0));
    send_item(CMD_LOOKUP, KEY_W'(21), TYPE_W'(3));
    send_item(CMD_LOOKUP, {KEY_W{1'b1}}, TYPE_W'(0));
    send_item(CMD_INSERT, KEY_W'(3), TYPE_W'(2));
    send_item(CMD_LOOKUP, KEY_W'('h2AAAAAAA), TYPE_W'(2));
    send_item(CMD_INSERT, KEY_W'('h55555555), TYPE_W'(1));

    run_phase(CFG_W'(0), 20);
    run_phase({CFG_W{1'b1}}, 180);
    run_phase(SIZE_RESET, 150);
    run_phase(CFG_W'(13), 120);
    run_phase(CFG_W'(1024), 60);
    run_phase(CFG_W'(6), 50);

    drain_replies();
    repeat (60) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending_replies.size() == 0)
      $display("double_hash_symbol_table: match");
    else
      $display("double_hash_symbol_table: mismatch");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("double_hash_symbol_table: mismatch");
    $finish;
  end

endmodule
